// ===== src/rdaqm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdaqm_pkg
// Shared types and constants of the adaptive early drop block.
// ----------------------------------------------------------------------------
package rdaqm_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [17:0] MID_RESET = 18'd12288;

  typedef enum logic [2:0] {
    CFG_MIN    = 3'd0,
    CFG_MAX    = 3'd1,
    CFG_WEIGHT = 3'd2,
    CFG_MAXP   = 3'd3,
    CFG_GROW   = 3'd4,
    CFG_SHRINK = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FORCED = 2'd1,
    KIND_RANDOM = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_AVG,
    OP_MUL_R1,
    OP_MUL_R2,
    OP_WR_R2,
    OP_MID,
    OP_CURVE,
    OP_DIV_STEP,
    OP_MUL_SQ,
    OP_MUL_CB,
    OP_MUL_P,
    OP_SET_P,
    OP_MUL_CNT,
    OP_PA,
    OP_DEC
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic below;
    logic forced;
    logic p_zero;
  } stat_t;

endpackage

// ===== src/rdaqm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdaqm_ctrl
// Sequencer that steps the datapath through one packet decision.
// ----------------------------------------------------------------------------
module rdaqm_ctrl import rdaqm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_AVG, S_R1, S_R2, S_WR2, S_MID, S_CURVE, S_DIV1,
    S_SQ, S_CB, S_MULP, S_SETP, S_CNT, S_PA, S_DIV2, S_DEC
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] div_cnt_r, div_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.op    = OP_MUL_AVG;
        state_nxt = S_R1;
      end
      S_R1: begin
        cmd.op    = OP_MUL_R1;
        state_nxt = S_R2;
      end
      S_R2: begin
        cmd.op    = OP_MUL_R2;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.op    = OP_WR_R2;
        state_nxt = S_MID;
      end
      S_MID: begin
        cmd.op    = OP_MID;
        state_nxt = S_CURVE;
      end
      S_CURVE: begin
        cmd.op      = OP_CURVE;
        div_cnt_nxt = 4'd0;
        state_nxt   = S_DIV1;
      end
      S_DIV1: begin
        if (stat.below || stat.forced) begin
          state_nxt = S_DEC;
        end else begin
          cmd.op      = OP_DIV_STEP;
          div_cnt_nxt = div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd15) begin
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.op    = OP_MUL_SQ;
        state_nxt = S_CB;
      end
      S_CB: begin
        cmd.op    = OP_MUL_CB;
        state_nxt = S_MULP;
      end
      S_MULP: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_SETP;
      end
      S_SETP: begin
        cmd.op    = OP_SET_P;
        state_nxt = S_CNT;
      end
      S_CNT: begin
        if (stat.p_zero) begin
          state_nxt = S_DEC;
        end else begin
          cmd.op    = OP_MUL_CNT;
          state_nxt = S_PA;
        end
      end
      S_PA: begin
        cmd.op      = OP_PA;
        div_cnt_nxt = 4'd0;
        state_nxt   = S_DIV2;
      end
      S_DIV2: begin
        cmd.op      = OP_DIV_STEP;
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd15) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_DEC;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/rdaqm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdaqm_dpath
// Registers, shared multiplier and restoring divider of the drop decision.
// ----------------------------------------------------------------------------
module rdaqm_dpath import rdaqm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic [9:0]         in_queue_length,
  input  logic [15:0]        in_random_value,
  output logic [1:0]         out_drop_kind,
  output logic [16:0]        out_drop_probability,
  output logic [25:0]        out_average_queue,
  output logic [17:0]        out_mid_threshold,
  output logic signed [27:0] out_rate_first,
  output logic signed [28:0] out_rate_second
);

  localparam logic signed [33:0] AVG_HI = 34'sd67108863;
  localparam logic signed [33:0] R1_HI  = 34'sd134217727;
  localparam logic signed [33:0] R1_LO  = -34'sd134217728;
  localparam logic signed [33:0] R2_HI  = 34'sd268435455;
  localparam logic signed [33:0] R2_LO  = -34'sd268435456;

  logic [9:0]  min_r, max_r;
  logic [13:0] bw_r;
  logic [16:0] maxp_r;
  logic [15:0] grow_r, shrink_r;
  logic [25:0] avg_r;
  logic [27:0] r1_r;
  logic [28:0] r2_r;
  logic [9:0]  last_r, older_r;
  logic [17:0] mid_r;
  logic [15:0] cnt_r;

  logic [9:0]  q_r;
  logic [15:0] rnd_r;
  logic [15:0] w_r;
  logic signed [48:0] prod_r;
  logic [26:0] rem_r;
  logic [25:0] den_r;
  logic [15:0] quot_r;
  logic [15:0] rr_r;
  logic [16:0] p_r;
  logic [15:0] cnt_inc_r;
  logic        pa_sat_r;
  logic        below_r, forced_r;

  logic [1:0]  okind_r;
  logic [16:0] oprob_r;
  logic [25:0] oavg_r;
  logic [17:0] omid_r;
  logic [27:0] or1_r;
  logic [28:0] or2_r;

  logic [25:0] min_f, max_f, upper;
  logic        outside, pos1, pos2, neg1;
  logic [15:0] w_load;
  logic [32:0] delta;
  logic [33:0] avg_sum, r1_sum, r2_sum;
  logic [25:0] avg_new;
  logic [27:0] r1_new;
  logic [28:0] r2_new;
  logic [10:0] s1;
  logic [11:0] s2;
  logic [30:0] mul_a;
  logic [17:0] mul_b;
  logic [20:0] mid_mov, mid_hi, mid_lo, mid_c;
  logic [17:0] mid_new;
  logic [16:0] maxp_sat;
  logic [26:0] rem_sh;
  logic        ge;
  logic [33:0] dd;
  logic        pa_sat;
  logic [16:0] pa;
  logic [1:0]  kind;
  logic [15:0] cnt_dec;

  assign cfg_ready = 1'b1;

  assign min_f   = {min_r, 16'b0};
  assign max_f   = {max_r, 16'b0};
  assign outside = (avg_r < min_f) || (avg_r >= max_f);
  assign w_load  = outside ? {bw_r, 2'b00} : {1'b0, bw_r, 1'b0};

  assign pos1 = !r1_r[27] && (r1_r != 28'd0);
  assign neg1 = r1_r[27];
  assign pos2 = !r2_r[28] && (r2_r != 29'd0);

  assign delta   = prod_r[48:16];
  assign avg_sum = {8'b0, avg_r} + {delta[32], delta};
  assign r1_sum  = {{6{r1_r[27]}}, r1_r} + {delta[32], delta};
  assign r2_sum  = {{5{r2_r[28]}}, r2_r} + {delta[32], delta};

  always_comb begin
    if ($signed(avg_sum) < 34'sd0) begin
      avg_new = 26'd0;
    end else if ($signed(avg_sum) > AVG_HI) begin
      avg_new = AVG_HI[25:0];
    end else begin
      avg_new = avg_sum[25:0];
    end
    if ($signed(r1_sum) > R1_HI) begin
      r1_new = R1_HI[27:0];
    end else if ($signed(r1_sum) < R1_LO) begin
      r1_new = R1_LO[27:0];
    end else begin
      r1_new = r1_sum[27:0];
    end
    if ($signed(r2_sum) > R2_HI) begin
      r2_new = R2_HI[28:0];
    end else if ($signed(r2_sum) < R2_LO) begin
      r2_new = R2_LO[28:0];
    end else begin
      r2_new = r2_sum[28:0];
    end
  end

  assign s1 = {1'b0, q_r} - {1'b0, last_r};
  assign s2 = {2'b0, q_r} - {1'b0, last_r, 1'b0} + {2'b0, older_r};

  assign maxp_sat = (maxp_r > ONE_Q16) ? ONE_Q16 : maxp_r;

  always_comb begin
    mul_a = 31'd0;
    mul_b = {2'b0, w_r};
    case (cmd.op)
      OP_MUL_AVG: mul_a = {5'b0, q_r, 16'b0} - {5'b0, avg_r};
      OP_MUL_R1:  mul_a = {{4{s1[10]}}, s1, 16'b0} - {{3{r1_r[27]}}, r1_r};
      OP_MUL_R2:  mul_a = {{3{s2[11]}}, s2, 16'b0} - {{2{r2_r[28]}}, r2_r};
      OP_MUL_SQ: begin
        mul_a = {15'b0, quot_r};
        mul_b = {2'b0, quot_r};
      end
      OP_MUL_CB: begin
        mul_a = {15'b0, prod_r[31:16]};
        mul_b = {2'b0, rr_r};
      end
      OP_MUL_P: begin
        mul_a = {15'b0, (pos2 ? rr_r : prod_r[31:16])};
        mul_b = {1'b0, maxp_sat};
      end
      OP_MUL_CNT: begin
        mul_a = {15'b0, cnt_inc_r};
        mul_b = {1'b0, p_r};
      end
      default: mul_a = 31'd0;
    endcase
  end

  always_comb begin
    mid_mov = {3'b0, mid_r};
    if (pos1) begin
      mid_mov = mid_mov - {5'b0, (pos2 ? grow_r : {1'b0, grow_r[15:1]})};
    end else if (neg1) begin
      mid_mov = mid_mov + {5'b0, (pos2 ? {1'b0, shrink_r[15:1]} : shrink_r)};
    end
    mid_hi = {3'b0, max_r, 8'b0} - 21'd256;
    mid_lo = {3'b0, min_r, 8'b0} + 21'd256;
    mid_c  = mid_mov;
    if ($signed(mid_c) > $signed(mid_hi)) begin
      mid_c = mid_hi;
    end
    if ($signed(mid_c) < $signed(mid_lo)) begin
      mid_c = mid_lo;
    end
    mid_new = ($signed(mid_c) > $signed(21'd262143)) ? 18'h3FFFF : mid_c[17:0];
  end

  assign upper  = pos1 ? {mid_r, 8'b0} : max_f;
  assign rem_sh = {rem_r[25:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  assign dd     = 34'h10000 - prod_r[33:0];
  assign pa_sat = dd[33] || (dd == 34'd0) || ({17'b0, p_r} >= dd);
  assign pa     = pa_sat_r ? ONE_Q16 : {1'b0, quot_r};

  always_comb begin
    if (forced_r) begin
      kind    = KIND_FORCED;
      cnt_dec = 16'd0;
    end else if (p_r == 17'd0) begin
      kind    = KIND_ACCEPT;
      cnt_dec = 16'd0;
    end else if ({1'b0, rnd_r} < pa) begin
      kind    = KIND_RANDOM;
      cnt_dec = 16'd0;
    end else begin
      kind    = KIND_ACCEPT;
      cnt_dec = cnt_inc_r;
    end
  end

  assign stat.below  = below_r;
  assign stat.forced = forced_r;
  assign stat.p_zero = (p_r == 17'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= 10'd24;
      max_r    <= 10'd72;
      bw_r     <= 14'd131;
      maxp_r   <= 17'd6554;
      grow_r   <= 16'd256;
      shrink_r <= 16'd256;
      avg_r    <= 26'd0;
      r1_r     <= 28'd0;
      r2_r     <= 29'd0;
      last_r   <= 10'd0;
      older_r  <= 10'd0;
      mid_r    <= MID_RESET;
      cnt_r    <= 16'd0;
      below_r  <= 1'b0;
      forced_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MIN: begin
            min_r <= cfg_data[9:0];
            mid_r <= {({1'b0, cfg_data[9:0]} + {1'b0, max_r}), 7'b0};
          end
          CFG_MAX: begin
            max_r <= cfg_data[9:0];
            mid_r <= {({1'b0, min_r} + {1'b0, cfg_data[9:0]}), 7'b0};
          end
          CFG_WEIGHT: bw_r     <= cfg_data[13:0];
          CFG_MAXP:   maxp_r   <= cfg_data;
          CFG_GROW:   grow_r   <= cfg_data[15:0];
          CFG_SHRINK: shrink_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      prod_r <= $signed(mul_a) * $signed(mul_b);
      case (cmd.op)
        OP_LOAD: begin
          q_r   <= in_queue_length;
          rnd_r <= in_random_value;
          w_r   <= w_load;
        end
        OP_MUL_R1: avg_r <= avg_new;
        OP_MUL_R2: r1_r  <= r1_new;
        OP_WR_R2: begin
          r2_r    <= r2_new;
          older_r <= last_r;
          last_r  <= q_r;
        end
        OP_MID: mid_r <= mid_new;
        OP_CURVE: begin
          below_r  <= avg_r < min_f;
          forced_r <= (avg_r >= min_f) && (avg_r >= upper);
          p_r      <= ((avg_r >= min_f) && (avg_r >= upper)) ? ONE_Q16 : 17'd0;
          rem_r    <= {1'b0, avg_r - min_f};
          den_r    <= upper - min_f;
        end
        OP_DIV_STEP: begin
          rem_r  <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
          quot_r <= {quot_r[14:0], ge};
        end
        OP_MUL_SQ: rr_r <= quot_r;
        OP_SET_P: begin
          p_r       <= {1'b0, prod_r[31:16]};
          cnt_inc_r <= (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
        end
        OP_PA: begin
          pa_sat_r <= pa_sat;
          rem_r    <= {10'b0, p_r};
          den_r    <= dd[25:0];
        end
        OP_DEC: begin
          cnt_r   <= cnt_dec;
          okind_r <= kind;
          oprob_r <= p_r;
          oavg_r  <= avg_r;
          omid_r  <= mid_r;
          or1_r   <= r1_r;
          or2_r   <= r2_r;
        end
        default: ;
      endcase
    end
  end

  assign out_drop_kind        = okind_r;
  assign out_drop_probability = oprob_r;
  assign out_average_queue    = oavg_r;
  assign out_mid_threshold    = omid_r;
  assign out_rate_first       = or1_r;
  assign out_rate_second      = or2_r;

endmodule

// ===== src/red_derivative_aqm_drop_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_derivative_aqm_drop_top
// Adaptive early drop decision with a movable mid threshold.
// ----------------------------------------------------------------------------
// Each request steps through the sequencer from acceptance to a valid result;
// the curve division and later steps are skipped when the average is below
// the minimum threshold or at the forced drop limit, and the second division
// when the base probability is zero. One shared multiplier serves every
// product in turn; a one-bit-per-cycle divider runs for the curve fraction
// and the count-corrected drop probability. A finished result waits in the
// output register while the next request is taken. Configuration has its own
// always-ready channel; thresholds reload the mid threshold to their midpoint.
module red_derivative_aqm_drop_top import rdaqm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         in_queue_length,
  input  logic [15:0]        in_random_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_drop_kind,
  output logic [16:0]        out_drop_probability,
  output logic [25:0]        out_average_queue,
  output logic [17:0]        out_mid_threshold,
  output logic signed [27:0] out_rate_first,
  output logic signed [28:0] out_rate_second
);

  cmd_t  cmd;
  stat_t stat;

  rdaqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rdaqm_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_queue_length      (in_queue_length),
    .in_random_value      (in_random_value),
    .out_drop_kind        (out_drop_kind),
    .out_drop_probability (out_drop_probability),
    .out_average_queue    (out_average_queue),
    .out_mid_threshold    (out_mid_threshold),
    .out_rate_first       (out_rate_first),
    .out_rate_second      (out_rate_second)
  );

endmodule
